// File: design/cwfd_pkg.sv
// Shared types and constants for the checksummed word frame deframer.
`timescale 1ns / 1ps
package cwfd_pkg;

  localparam logic [7:0] SYNC_RESET = 8'hAA;
  localparam logic [7:0] FUNC_RESET = 8'hF1;

  localparam logic [0:0] REG_SYNC = 1'b0;
  localparam logic [0:0] REG_FUNC = 1'b1;

  // frame queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
    logic head;
  } qstat_t;

endpackage

// File: design/cwfd_front.sv
// Front end: sync hunt, frame collection, header and checksum checks, word store writes.
`timescale 1ns / 1ps
module cwfd_front #(
  parameter int WORD_COUNT = 22
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  input  cwfd_pkg::qstat_t     qs,
  output logic                 push,
  output logic                 push_bank,
  output logic                 mem_we,
  output logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1):0] mem_addr,
  output logic [31:0]          mem_data
);
  import cwfd_pkg::*;

  localparam int FRAME_LEN = 4 * WORD_COUNT + 4;
  localparam int PW = $clog2(FRAME_LEN);
  localparam int IW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic [7:0]    sync_byte;
  logic [7:0]    function_code;
  logic          collecting;
  logic [PW-1:0] pos;
  logic [7:0]    sum;
  logic          hdr_good;
  logic          wr_bank;
  logic [1:0]    lane;
  logic [IW-1:0] widx;
  logic [23:0]   shreg;

  logic take;
  logic is_final;
  logic in_payload;

  assign in_stall   = qs.full;
  assign take       = in_valid && !in_stall;
  assign is_final   = pos == PW'(FRAME_LEN - 1);
  assign in_payload = pos >= PW'(3);

  assign mem_we    = take && collecting && !is_final && in_payload && (lane == 2'd3);
  assign mem_addr  = {wr_bank, widx};
  assign mem_data  = {shreg, rx_byte};
  assign push      = take && collecting && is_final && hdr_good && (rx_byte == sum);
  assign push_bank = wr_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= SYNC_RESET;
      function_code <= FUNC_RESET;
      collecting    <= 1'b0;
      pos           <= '0;
      sum           <= '0;
      hdr_good      <= 1'b0;
      wr_bank       <= 1'b0;
      lane          <= '0;
      widx          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC: sync_byte     <= cfg_data;
          REG_FUNC: function_code <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        if (!collecting) begin
          if (rx_byte == sync_byte) begin
            collecting <= 1'b1;
            pos        <= '0;
            sum        <= rx_byte;
            hdr_good   <= 1'b1;
            lane       <= '0;
            widx       <= '0;
          end
        end else if (!is_final) begin
          if (pos == PW'(0) && rx_byte != sync_byte) hdr_good <= 1'b0;
          if (pos == PW'(1) && rx_byte != function_code) hdr_good <= 1'b0;
          if (in_payload) begin
            lane <= lane + 2'd1;
            if (lane == 2'd3) widx <= widx + IW'(1);
          end
          sum <= sum + rx_byte;
          pos <= pos + PW'(1);
        end else begin
          collecting <= 1'b0;
          pos        <= '0;
          sum        <= '0;
          hdr_good   <= 1'b0;
          if (push) wr_bank <= ~wr_bank;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && collecting && !is_final && in_payload && lane != 2'd3) begin
      shreg <= {shreg[15:0], rx_byte};
    end
  end

endmodule

// File: design/cwfd_queue.sv
// Two-entry queue of accepted frames, each entry naming its word store bank.
`timescale 1ns / 1ps
module cwfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             push_bank,
  input  logic             pop,
  output cwfd_pkg::qstat_t qs
);
  import cwfd_pkg::*;

  logic       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign qs.empty = count == 2'd0;
  assign qs.full  = count == 2'd2;
  assign qs.head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_bank;
  end

endmodule

// File: design/cwfd_back.sv
// Back end: two-bank word store and word beat sequencer with output register.
`timescale 1ns / 1ps
module cwfd_back #(
  parameter int WORD_COUNT = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  cwfd_pkg::qstat_t qs,
  output logic             pop,
  input  logic             mem_we,
  input  logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1):0] mem_addr,
  input  logic [31:0]      mem_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [4:0]       word_index,
  output logic [31:0]      word_value,
  output logic             last_word
);
  import cwfd_pkg::*;

  localparam int IW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int DEPTH = 2 ** (IW + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  state_t        state;
  logic [IW-1:0] rd_idx;
  logic          load;
  logic          last;

  assign last = rd_idx == IW'(WORD_COUNT - 1);
  assign load = (state == S_LOAD) && (!out_valid || !out_stall);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_data;
    rdata <= mem[{qs.head, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_idx <= '0;
          if (!qs.empty) state <= S_READ;
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          if (load) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + IW'(1);
              state  <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_value <= rdata;
      word_index <= 5'(rd_idx);
      last_word  <= last;
    end
  end

endmodule

// File: design/checksummed_word_frame_deframer_unit.sv
// Top level of the checksummed word frame deframer.
// Takes one received byte per cycle while in_stall is low. After a sync byte it
// collects a frame of 4*WORD_COUNT+4 bytes; a frame with good header and 8-bit
// additive checksum yields WORD_COUNT beats of big-endian 32-bit words, with one
// store read plus one output load per word, and out_stall holds the beats. Words go
// into a two-bank store, so the next frame is collected while the previous one
// drains; input is stalled only while both banks hold frames that are still
// waiting to drain.
`timescale 1ns / 1ps
module checksummed_word_frame_deframer_unit #(
  parameter int WORD_COUNT = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  word_index,
  output logic [31:0] word_value,
  output logic        last_word
);
  import cwfd_pkg::*;

  localparam int IW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  qstat_t      qs;
  logic        push;
  logic        push_bank;
  logic        pop;
  logic        mem_we;
  logic [IW:0] mem_addr;
  logic [31:0] mem_data;

  cwfd_front #(.WORD_COUNT(WORD_COUNT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .qs        (qs),
    .push      (push),
    .push_bank (push_bank),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data)
  );

  cwfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bank (push_bank),
    .pop       (pop),
    .qs        (qs)
  );

  cwfd_back #(.WORD_COUNT(WORD_COUNT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .qs         (qs),
    .pop        (pop),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_data   (mem_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .word_value (word_value),
    .last_word  (last_word)
  );

endmodule

// File: design/cwfd_checker.sv
// Port-level checks on the deframer output, bound to the top level.
`timescale 1ns / 1ps
module cwfd_checker #(
  parameter int WORD_COUNT = 22
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  word_index,
  input logic [31:0] word_value,
  input logic        last_word
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(word_value) && $stable(word_index)
      && $stable(last_word))
    else $error("stalled beat changed");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_word |-> word_index == 5'(WORD_COUNT - 1))
    else $error("last beat at wrong word index");

  a_next_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word
      |=> !out_valid || word_index == 5'($past(word_index) + 5'd1))
    else $error("word index does not advance by one");

endmodule

bind checksummed_word_frame_deframer_unit cwfd_checker #(.WORD_COUNT(WORD_COUNT)) u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .word_index (word_index),
  .word_value (word_value),
  .last_word  (last_word)
);
